### rtl/core/esd_pkg.sv
// -----------------------------------------------------------------------------
// esd_pkg: shared types and helpers for the escape sequence decoder
// Payload structs, controller/datapath command and status, mode codes and
// character helpers for hex digits and numeric escape letters.
// -----------------------------------------------------------------------------
package esd_pkg;

   localparam int HELD_DEPTH = 8;
   localparam int HELD_IDX_W = $clog2(HELD_DEPTH);

   localparam logic [15:0] CH_BACKSLASH = 16'h005C;
   localparam logic [15:0] CH_ESCAPE    = 16'h001B;
   localparam logic [31:0] UNIT_MAX     = 32'h0000_FFFF;

   typedef struct packed {
      logic [15:0] in_unit;
      logic        in_final;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] out_unit;
      logic        out_final;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      MODE_TEXT   = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_DIGITS = 2'd2
   } scan_mode_type;

   typedef enum logic [1:0] {
      KIND_X     = 2'd0,
      KIND_U     = 2'd1,
      KIND_BIG_U = 2'd2
   } escape_kind_type;

   // Which part of the latched output plan goes out next
   typedef enum logic [1:0] {
      SEL_HEAD0 = 2'd0,
      SEL_HEAD1 = 2'd1,
      SEL_HELD  = 2'd2,
      SEL_TAIL  = 2'd3
   } emit_sel_type;

   typedef struct packed {
      logic         load;
      logic         emit;
      emit_sel_type sel;
      logic         last;
   } esd_cmd_type;

   typedef struct packed {
      logic plan_any;
      logic has_head1;
      logic has_held;
      logic held_last;
      logic has_tail;
      logic out_free;
   } esd_status_type;

   // Bit 4 flags a valid digit, bits 3:0 hold its value
   function automatic logic [4:0] hex_digit(input logic [15:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 16'h0030 && c <= 16'h0039) begin
         r = {1'b1, 4'(c - 16'h0030)};
      end else if (c >= 16'h0061 && c <= 16'h0066) begin
         r = {1'b1, 4'(c - 16'h0057)};
      end else if (c >= 16'h0041 && c <= 16'h0046) begin
         r = {1'b1, 4'(c - 16'h0037)};
      end
      return r;
   endfunction

   function automatic logic [3:0] digits_needed(input escape_kind_type k);
      logic [3:0] r;
      case (k)
         KIND_X:  r = 4'd2;
         KIND_U:  r = 4'd4;
         default: r = 4'd8;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] kind_letter(input escape_kind_type k);
      logic [15:0] r;
      case (k)
         KIND_X:  r = 16'h0078;
         KIND_U:  r = 16'h0075;
         default: r = 16'h0055;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/esd_datapath.sv
// -----------------------------------------------------------------------------
// esd_datapath: escape decoding state, output plan and result register
// Decodes one accepted unit into a plan of up to ten result units, holds the
// digits of a pending numeric escape and replays them on a failed escape.
// -----------------------------------------------------------------------------
module esd_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  esd_pkg::req_payload_type req_payload,
   input  esd_pkg::esd_cmd_type     cmd,
   output esd_pkg::esd_status_type  status,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output esd_pkg::rsp_payload_type rsp_payload
);
   import esd_pkg::*;

   // escape scanner state
   scan_mode_type         mode_ff, mode_in;
   escape_kind_type       kind_ff, kind_in;
   logic [HELD_IDX_W-1:0] dcount_ff, dcount_in;
   logic [31:0]           code_ff, code_in;
   logic [15:0]           held_ff [HELD_DEPTH];
   logic                  hold_we;

   // latched output plan
   logic [15:0]           head0_ff, head0_in;
   logic [15:0]           head1_ff, head1_in;
   logic                  two_ff, two_in;
   logic [HELD_IDX_W-1:0] held_n_ff, held_n_in;
   logic                  tail_ff, tail_in;
   logic                  any_in;
   logic [15:0]           unit_ff;
   logic                  fin_ff;
   logic [HELD_IDX_W-1:0] rep_idx_ff, rep_idx_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [15:0]           rsp_unit_ff, rsp_unit_in;
   logic                  rsp_final_ff;

   logic [15:0]           c;
   logic                  fin;
   logic [4:0]            hex;
   logic [31:0]           code_next;
   logic                  complete;

   assign c         = req_payload.in_unit;
   assign fin       = req_payload.in_final;
   assign hex       = hex_digit(c);
   assign code_next = {code_ff[27:0], hex[3:0]};
   assign complete  = ({1'b0, dcount_ff} + 4'd1) >= digits_needed(kind_ff);

   always_comb begin
      mode_in   = mode_ff;
      kind_in   = kind_ff;
      dcount_in = dcount_ff;
      code_in   = code_ff;
      hold_we   = 1'b0;
      head0_in  = c;
      head1_in  = c;
      two_in    = 1'b0;
      held_n_in = '0;
      tail_in   = 1'b0;
      any_in    = 1'b0;
      case (mode_ff)
         MODE_ESCAPE: begin
            mode_in = MODE_TEXT;
            any_in  = 1'b1;
            case (c)
               16'h0061: head0_in = 16'h0007;
               16'h0062: head0_in = 16'h0008;
               16'h0065: head0_in = CH_ESCAPE;
               16'h0066: head0_in = 16'h000C;
               16'h006E: head0_in = 16'h000A;
               16'h0072: head0_in = 16'h000D;
               16'h0074: head0_in = 16'h0009;
               16'h0076: head0_in = 16'h000B;
               16'h005C, 16'h003F, 16'h0027, 16'h0022: head0_in = c;
               16'h0078, 16'h0075, 16'h0055: begin
                  if (fin) begin
                     head0_in = CH_BACKSLASH;
                     two_in   = 1'b1;
                  end else begin
                     any_in    = 1'b0;
                     mode_in   = MODE_DIGITS;
                     kind_in   = (c == 16'h0078) ? KIND_X :
                                 (c == 16'h0075) ? KIND_U : KIND_BIG_U;
                     dcount_in = '0;
                     code_in   = '0;
                  end
               end
               default: begin
                  head0_in = CH_BACKSLASH;
                  two_in   = 1'b1;
               end
            endcase
         end
         MODE_DIGITS: begin
            if (hex[4]) begin
               code_in = code_next;
               if (complete) begin
                  mode_in   = MODE_TEXT;
                  dcount_in = '0;
                  any_in    = 1'b1;
                  if (kind_ff == KIND_X) begin
                     head0_in = {8'h00, code_next[7:0]};
                  end else if (kind_ff == KIND_U || code_next <= UNIT_MAX) begin
                     head0_in = code_next[15:0];
                  end else begin
                     // surrogate pair, high half truncated to 16 bits
                     head0_in = code_next[25:10] + 16'hD7C0;
                     head1_in = {6'b110111, code_next[9:0]};
                     two_in   = 1'b1;
                  end
               end else if (fin) begin
                  mode_in   = MODE_TEXT;
                  dcount_in = '0;
                  any_in    = 1'b1;
                  head0_in  = CH_BACKSLASH;
                  head1_in  = kind_letter(kind_ff);
                  two_in    = 1'b1;
                  held_n_in = dcount_ff;
                  tail_in   = 1'b1;
               end else begin
                  hold_we   = 1'b1;
                  dcount_in = dcount_ff + 1'b1;
               end
            end else begin
               // failed escape: replay, then treat the unit as plain text or a new escape start
               mode_in   = MODE_TEXT;
               dcount_in = '0;
               any_in    = 1'b1;
               head0_in  = CH_BACKSLASH;
               head1_in  = kind_letter(kind_ff);
               two_in    = 1'b1;
               held_n_in = dcount_ff;
               if (c == CH_BACKSLASH && !fin) begin
                  mode_in = MODE_ESCAPE;
               end else begin
                  tail_in = 1'b1;
               end
            end
         end
         default: begin
            mode_in = MODE_TEXT;
            if (c == CH_BACKSLASH && !fin) begin
               mode_in = MODE_ESCAPE;
            end else begin
               any_in = 1'b1;
            end
         end
      endcase
      if (fin) begin
         mode_in   = MODE_TEXT;
         dcount_in = '0;
      end
   end

   always_comb begin
      rep_idx_in = rep_idx_ff;
      if (cmd.load) begin
         rep_idx_in = '0;
      end else if (cmd.emit && cmd.sel == SEL_HELD) begin
         rep_idx_in = rep_idx_ff + 1'b1;
      end
   end

   always_comb begin
      case (cmd.sel)
         SEL_HEAD0: rsp_unit_in = head0_ff;
         SEL_HEAD1: rsp_unit_in = head1_ff;
         SEL_HELD:  rsp_unit_in = held_ff[rep_idx_ff];
         SEL_TAIL:  rsp_unit_in = unit_ff;
         default:   rsp_unit_in = unit_ff;
      endcase
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_TEXT;
         kind_ff      <= KIND_X;
         dcount_ff    <= '0;
         code_ff      <= '0;
         rep_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            mode_ff   <= mode_in;
            kind_ff   <= kind_in;
            dcount_ff <= dcount_in;
            code_ff   <= code_in;
         end
         rep_idx_ff   <= rep_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         head0_ff  <= head0_in;
         head1_ff  <= head1_in;
         two_ff    <= two_in;
         held_n_ff <= held_n_in;
         tail_ff   <= tail_in;
         unit_ff   <= c;
         fin_ff    <= fin;
         if (hold_we) begin
            held_ff[dcount_ff] <= c;
         end
      end
      if (cmd.emit) begin
         rsp_unit_ff  <= rsp_unit_in;
         rsp_final_ff <= fin_ff & cmd.last;
      end
   end

   assign status.plan_any  = any_in;
   assign status.has_head1 = two_ff;
   assign status.has_held  = (held_n_ff != '0);
   assign status.held_last = (rep_idx_ff == held_n_ff - 1'b1);
   assign status.has_tail  = tail_ff;
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_payload.out_unit    = rsp_unit_ff;
   assign rsp_payload.out_final   = rsp_final_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result register overwritten while stalled");

   a_final_text: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && req_payload.in_final) |=> (mode_ff == MODE_TEXT && dcount_ff == '0))
      else $error("scanner not back to plain text after final unit");

   a_digit_bound: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_DIGITS) |-> (({1'b0, dcount_ff}) < digits_needed(kind_ff)))
      else $error("held digit count exceeds escape length");

endmodule

### rtl/core/esd_controller.sv
// -----------------------------------------------------------------------------
// esd_controller: sequencer for the escape sequence decoder
// Accepts one transaction while idle, then steps the datapath through the
// latched output plan, one result per free slot of the result register.
// -----------------------------------------------------------------------------
module esd_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output esd_pkg::esd_cmd_type    cmd,
   input  esd_pkg::esd_status_type status
);
   import esd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_HEAD0 = 5'b00010,
      ST_HEAD1 = 5'b00100,
      ST_HELD  = 5'b01000,
      ST_TAIL  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '{load: 1'b0, emit: 1'b0, sel: SEL_HEAD0, last: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.plan_any) begin
                  state_in = ST_HEAD0;
               end
            end
         end
         ST_HEAD0: begin
            cmd.sel  = SEL_HEAD0;
            cmd.last = !status.has_head1 && !status.has_held && !status.has_tail;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.has_head1 ? ST_HEAD1 :
                          status.has_held  ? ST_HELD  :
                          status.has_tail  ? ST_TAIL  : ST_IDLE;
            end
         end
         ST_HEAD1: begin
            cmd.sel  = SEL_HEAD1;
            cmd.last = !status.has_held && !status.has_tail;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.has_held ? ST_HELD :
                          status.has_tail ? ST_TAIL : ST_IDLE;
            end
         end
         ST_HELD: begin
            cmd.sel  = SEL_HELD;
            cmd.last = status.held_last && !status.has_tail;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.held_last) begin
                  state_in = status.has_tail ? ST_TAIL : ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            cmd.sel  = SEL_TAIL;
            cmd.last = 1'b1;
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // hold off the sender while in reset or while not idle
   assign req_stall = reset || (state_ff != ST_IDLE);

   a_load_start: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && status.plan_any) |=> (state_ff == ST_HEAD0))
      else $error("plan with results not started");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && !status.plan_any) |=> (state_ff == ST_IDLE))
      else $error("empty plan left the sequencer busy");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("sequencer busy after last result");

endmodule

### rtl/core/escape_sequence_decoder_top.sv
// -----------------------------------------------------------------------------
// escape_sequence_decoder_top: C-style backslash escape decoder, UTF-16 units
// Input transactions carry one code unit and an end-of-text flag; result
// transactions carry one decoded unit and a flag on the last result of the
// transaction that ended the text. Both channels use valid/stall.
// A transaction is taken while the sequencer is idle; it then yields zero to
// ten results, one per cycle while rsp_stall is low. The decoded plan is
// latched on acceptance, then each result goes into the single result
// register and is offered on rsp_valid. No new transaction is taken until
// the plan is done; one that yields nothing, e.g. inside an escape, leaves
// the sequencer idle. A failed numeric escape replays up to seven held
// digits through the result register in the same way.
// The result register is free to take a new result while the receiver takes
// the previous one; while rsp_stall is high the result holds and the
// sequencer waits, and req_stall stays high until the plan is done.
// Synchronous reset returns the scanner to plain text and drops any pending
// result; req_stall is high while reset is asserted.
// -----------------------------------------------------------------------------
module escape_sequence_decoder_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  esd_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output esd_pkg::rsp_payload_type rsp_payload
);
   import esd_pkg::*;

   esd_cmd_type    ctl_cmd;
   esd_status_type dp_status;

   esd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (ctl_cmd),
      .status    (dp_status)
   );

   esd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (ctl_cmd),
      .status      (dp_status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
